// File: design/xml_reference_parser_core_defines.svh
// assertion macros for the xml reference parser
`ifndef XML_REFERENCE_PARSER_CORE_DEFINES_SVH
`define XML_REFERENCE_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH
`define XRP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("xrp assertion failed");
`define XRP_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("xrp assertion failed");
`else
`define XRP_ASSERT(lbl, clk, rst_n, prop)
`define XRP_ASSERT_NEXT(lbl, clk, rst_n, cond, prop)
`endif

`endif

// File: design/xrp_pkg.sv
package xrp_pkg;

    localparam int CP_W = 21;
    localparam int ST_W = 3;
    localparam int PH_W = 3;
    localparam int MUL_W = CP_W + 4;

    localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
    localparam logic [CP_W-1:0] CH_AMP  = 21'h000026;
    localparam logic [CP_W-1:0] CH_HASH = 21'h000023;
    localparam logic [CP_W-1:0] CH_X    = 21'h000078;
    localparam logic [CP_W-1:0] CH_SEMI = 21'h00003B;

    localparam logic [PH_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PH_W-1:0] PH_TYPE  = 3'd1;
    localparam logic [PH_W-1:0] PH_NAME  = 3'd2;
    localparam logic [PH_W-1:0] PH_CTYPE = 3'd3;
    localparam logic [PH_W-1:0] PH_DEC   = 3'd4;
    localparam logic [PH_W-1:0] PH_HEX   = 3'd5;

    localparam logic [ST_W-1:0] ST_CONSUMED = 3'd0;
    localparam logic [ST_W-1:0] ST_NAMECHAR = 3'd1;
    localparam logic [ST_W-1:0] ST_ENTDONE  = 3'd2;
    localparam logic [ST_W-1:0] ST_CHARDONE = 3'd3;
    localparam logic [ST_W-1:0] ST_ERROR    = 3'd4;

    typedef struct packed {
        logic name_start;
        logic name_char;
        logic dec_digit;
        logic hex_digit;
        logic [3:0] digit_val;
        logic xml_char;
    } t_char_class;

endpackage

// File: design/xrp_char_class.sv
module xrp_char_class
    import xrp_pkg::*;
(
    input  logic [CP_W-1:0] i_code_point,
    input  logic [CP_W-1:0] i_acc_value,
    output t_char_class     o_class
);

    function automatic logic in_rng(input logic [CP_W-1:0] c, input logic [CP_W-1:0] lo,
                                    input logic [CP_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    logic [CP_W-1:0] c;
    logic            start_c;
    logic            lower_hex;
    logic            upper_hex;

    assign c = i_code_point;

    assign start_c = (c == 21'h3A) || (c == 21'h5F) ||
                     in_rng(c, 21'h41, 21'h5A) || in_rng(c, 21'h61, 21'h7A) ||
                     in_rng(c, 21'hC0, 21'hD6) || in_rng(c, 21'hD8, 21'hF6) ||
                     in_rng(c, 21'hF8, 21'h2FF) || in_rng(c, 21'h370, 21'h37D) ||
                     in_rng(c, 21'h37F, 21'h1FFF) || in_rng(c, 21'h200C, 21'h200D) ||
                     in_rng(c, 21'h2070, 21'h218F) || in_rng(c, 21'h2C00, 21'h2FEF) ||
                     in_rng(c, 21'h3001, 21'hD7FF) || in_rng(c, 21'hF900, 21'hFDCF) ||
                     in_rng(c, 21'hFDF0, 21'hFFFD) || in_rng(c, 21'h10000, 21'hEFFFF);

    assign lower_hex = in_rng(c, 21'h61, 21'h66);
    assign upper_hex = in_rng(c, 21'h41, 21'h46);

    always_comb begin
        o_class.name_start = start_c;
        o_class.dec_digit  = in_rng(c, 21'h30, 21'h39);
        o_class.name_char  = start_c || (c == 21'h2D) || (c == 21'h2E) ||
                             o_class.dec_digit || (c == 21'hB7) ||
                             in_rng(c, 21'h300, 21'h36F) || in_rng(c, 21'h203F, 21'h2040);
        o_class.hex_digit  = o_class.dec_digit || lower_hex || upper_hex;
        o_class.digit_val  = o_class.dec_digit ? c[3:0] : c[3:0] + 4'd9;
        o_class.xml_char   = (i_acc_value == 21'h9) || (i_acc_value == 21'hA) ||
                             (i_acc_value == 21'hD) ||
                             in_rng(i_acc_value, 21'h20, 21'hD7FF) ||
                             in_rng(i_acc_value, 21'hE000, 21'hFFFD) ||
                             in_rng(i_acc_value, 21'h10000, CP_MAX);
    end

endmodule

// File: design/xml_reference_parser_core.sv
// a result is registered and valid in the cycle after its item is accepted
// throughput: one item per cycle; the single output register is refilled
// in the cycle it is taken, so only a stalled output holds off input
// reset: i_rst_n low at a clock edge returns the parser to idle, clears
// the digit accumulator and drops the output valid
`include "xml_reference_parser_core_defines.svh"

module xml_reference_parser_core
    import xrp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [CP_W-1:0] i_code_point,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [ST_W-1:0] o_status,
    output logic [CP_W-1:0] o_value
);

    logic [PH_W-1:0] r_phase, n_phase;
    logic [CP_W-1:0] r_acc, n_acc;
    logic            r_seen, n_seen;
    logic            r_out_valid;
    logic [ST_W-1:0] r_status, n_status;
    logic [CP_W-1:0] r_value, n_value;

    t_char_class     cls;
    logic            accept;
    logic            is_hex;
    logic [MUL_W-1:0] mul;
    logic [MUL_W-1:0] sum;
    logic            digit_ok;

    xrp_char_class u_class (
        .i_code_point (i_code_point),
        .i_acc_value  (r_acc),
        .o_class      (cls)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // digit accumulate: acc * base + digit
    assign is_hex   = (r_phase == PH_HEX);
    assign mul      = is_hex ? {r_acc, 4'b0000}
                             : {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
    assign sum      = mul + {{(MUL_W-4){1'b0}}, cls.digit_val};
    assign digit_ok = is_hex ? cls.hex_digit : cls.dec_digit;

    always_comb begin
        n_status = ST_ERROR;
        n_value  = i_code_point;
        n_phase  = PH_IDLE;
        n_acc    = r_acc;
        n_seen   = r_seen;
        unique case (r_phase) inside
            PH_TYPE: begin
                if (i_code_point == CH_HASH) begin
                    n_status = ST_CONSUMED;
                    n_value  = '0;
                    n_phase  = PH_CTYPE;
                end else if (cls.name_start) begin
                    n_status = ST_NAMECHAR;
                    n_phase  = PH_NAME;
                end
            end
            PH_NAME: begin
                if (i_code_point == CH_SEMI) begin
                    n_status = ST_ENTDONE;
                    n_value  = '0;
                end else if (cls.name_char) begin
                    n_status = ST_NAMECHAR;
                    n_phase  = PH_NAME;
                end
            end
            PH_CTYPE: begin
                if (i_code_point == CH_X) begin
                    n_status = ST_CONSUMED;
                    n_value  = '0;
                    n_phase  = PH_HEX;
                    n_acc    = '0;
                    n_seen   = 1'b0;
                end else if (cls.dec_digit) begin
                    n_status = ST_CONSUMED;
                    n_value  = '0;
                    n_phase  = PH_DEC;
                    n_acc    = {{(CP_W-4){1'b0}}, cls.digit_val};
                    n_seen   = 1'b1;
                end
            end
            PH_DEC, PH_HEX: begin
                if (i_code_point == CH_SEMI) begin
                    if (r_seen && cls.xml_char) begin
                        n_status = ST_CHARDONE;
                        n_value  = r_acc;
                    end
                end else if (digit_ok && (sum <= {{(MUL_W-CP_W){1'b0}}, CP_MAX})) begin
                    n_status = ST_CONSUMED;
                    n_value  = '0;
                    n_phase  = r_phase;
                    n_acc    = sum[CP_W-1:0];
                    n_seen   = 1'b1;
                end
            end
            default: begin
                if (i_code_point == CH_AMP) begin
                    n_status = ST_CONSUMED;
                    n_value  = '0;
                    n_phase  = PH_TYPE;
                end
            end
        endcase
        if (n_phase == PH_IDLE) begin
            n_acc  = '0;
            n_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_seen  <= n_seen;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_value  <= n_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value     = r_value;

    `XRP_ASSERT(a_idle_clear, i_clk, i_rst_n, (r_phase == PH_IDLE) |-> (!r_seen && (r_acc == '0)))
    `XRP_ASSERT(a_acc_range, i_clk, i_rst_n, r_acc <= CP_MAX)
    `XRP_ASSERT(a_dec_seen, i_clk, i_rst_n, (r_phase == PH_DEC) |-> r_seen)
    `XRP_ASSERT_NEXT(a_err_idle, i_clk, i_rst_n, accept && (n_status == ST_ERROR), (r_phase == PH_IDLE) && o_out_valid && (o_status == ST_ERROR))

endmodule

// File: tb/sv/testbench.sv
module testbench
    import xrp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEM_GOAL = 750;

    typedef struct {
        logic [CP_W-1:0] cp;
        bit              hold;
    } t_char_item;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [CP_W-1:0] value;
    } t_parse_result;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_ready;
    logic [CP_W-1:0] i_code_point = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    logic [ST_W-1:0] o_status;
    logic [CP_W-1:0] o_value;

    t_char_item    char_items[$];
    t_parse_result due_results[$];

    bit          in_taken = 1'b0;
    bit          pause_next = 1'b0;
    int unsigned queued = 0;
    int unsigned items_taken = 0;
    int unsigned results_seen = 0;
    int unsigned failures = 0;
    int unsigned status_tally[5] = '{default: 0};

    // parser state as predicted
    logic [PH_W-1:0] parse_phase = PH_IDLE;
    int unsigned     digit_acc = 0;
    bit              digit_seen = 1'b0;

    xml_reference_parser_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_code_point (i_code_point),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_value      (o_value)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit in_span(int unsigned c, int unsigned lo, int unsigned hi);
        return c >= lo && c <= hi;
    endfunction

    function automatic bit starts_name(int unsigned c);
        return c == ":" || c == "_" || in_span(c, "A", "Z") || in_span(c, "a", "z") ||
               in_span(c, 'hC0, 'hD6) || in_span(c, 'hD8, 'hF6) ||
               in_span(c, 'hF8, 'h2FF) || in_span(c, 'h370, 'h37D) ||
               in_span(c, 'h37F, 'h1FFF) || in_span(c, 'h200C, 'h200D) ||
               in_span(c, 'h2070, 'h218F) || in_span(c, 'h2C00, 'h2FEF) ||
               in_span(c, 'h3001, 'hD7FF) || in_span(c, 'hF900, 'hFDCF) ||
               in_span(c, 'hFDF0, 'hFFFD) || in_span(c, 'h10000, 'hEFFFF);
    endfunction

    function automatic bit continues_name(int unsigned c);
        return starts_name(c) || c == "-" || c == "." || in_span(c, "0", "9") ||
               c == 'hB7 || in_span(c, 'h300, 'h36F) || in_span(c, 'h203F, 'h2040);
    endfunction

    function automatic bit legal_char(int unsigned c);
        return c == 'h9 || c == 'hA || c == 'hD || in_span(c, 'h20, 'hD7FF) ||
               in_span(c, 'hE000, 'hFFFD) || in_span(c, 'h10000, CP_MAX);
    endfunction

    // 16 marks a character that is no digit of the base
    function automatic int unsigned digit_weight(int unsigned c, int unsigned base);
        if (in_span(c, "0", "9")) begin
            return c - "0";
        end
        if (base == 16) begin
            if (in_span(c, "a", "f")) begin
                return c - "a" + 10;
            end
            if (in_span(c, "A", "F")) begin
                return c - "A" + 10;
            end
        end
        return 16;
    endfunction

    function automatic t_parse_result parse_step(logic [CP_W-1:0] cp);
        int unsigned     c;
        int unsigned     base;
        int unsigned     d;
        int unsigned     sum;
        logic [ST_W-1:0] st;
        int unsigned     val;
        logic [PH_W-1:0] nxt;
        c = cp;
        st = ST_ERROR;
        val = c;
        nxt = PH_IDLE;
        case (parse_phase) inside
            PH_TYPE: begin
                if (cp == CH_HASH) begin
                    st = ST_CONSUMED; val = 0; nxt = PH_CTYPE;
                end else if (starts_name(c)) begin
                    st = ST_NAMECHAR; nxt = PH_NAME;
                end
            end
            PH_NAME: begin
                if (cp == CH_SEMI) begin
                    st = ST_ENTDONE; val = 0;
                end else if (continues_name(c)) begin
                    st = ST_NAMECHAR; nxt = PH_NAME;
                end
            end
            PH_CTYPE: begin
                if (cp == CH_X) begin
                    st = ST_CONSUMED; val = 0; nxt = PH_HEX;
                    digit_acc = 0; digit_seen = 1'b0;
                end else if (in_span(c, "0", "9")) begin
                    st = ST_CONSUMED; val = 0; nxt = PH_DEC;
                    digit_acc = c - "0"; digit_seen = 1'b1;
                end
            end
            PH_DEC, PH_HEX: begin
                base = (parse_phase == PH_HEX) ? 16 : 10;
                d = digit_weight(c, base);
                if (cp == CH_SEMI) begin
                    if (digit_seen && legal_char(digit_acc)) begin
                        st = ST_CHARDONE; val = digit_acc;
                    end
                end else if (d < base) begin
                    sum = digit_acc * base + d;
                    if (sum <= CP_MAX) begin
                        st = ST_CONSUMED; val = 0; nxt = parse_phase;
                        digit_acc = sum; digit_seen = 1'b1;
                    end
                end
            end
            default: begin
                if (cp == CH_AMP) begin
                    st = ST_CONSUMED; val = 0; nxt = PH_TYPE;
                end
            end
        endcase
        if (nxt == PH_IDLE) begin
            digit_acc = 0;
            digit_seen = 1'b0;
        end
        parse_phase = nxt;
        return '{status: st, value: val[CP_W-1:0]};
    endfunction

    task automatic add_char(int unsigned cp);
        t_char_item item;
        item.cp = cp[CP_W-1:0];
        item.hold = pause_next;
        char_items = {char_items, item};
        pause_next = 1'b0;
        queued++;
    endtask

    task automatic add_text(string s);
        foreach (s[i]) begin
            add_char(s[i]);
        end
    endtask

    function automatic int unsigned pick_any();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 127);
            1: begin
                case ($urandom_range(0, 4))
                    0: return CH_AMP;
                    1: return CH_HASH;
                    2: return CH_X;
                    3: return "X";
                    default: return CH_SEMI;
                endcase
            end
            default: return $urandom_range(0, CP_MAX);
        endcase
    endfunction

    function automatic int unsigned pick_name_start();
        case ($urandom_range(0, 7))
            0: return $urandom_range("A", "Z");
            1: return $urandom_range("a", "z");
            2: return $urandom_range(0, 1) ? ":" : "_";
            3: return $urandom_range('hC0, 'hD6);
            4: return $urandom_range('hF8, 'h2FF);
            5: return $urandom_range('h370, 'h37D);
            6: return $urandom_range('h3001, 'hD7FF);
            default: return $urandom_range('h10000, 'hEFFFF);
        endcase
    endfunction

    function automatic int unsigned pick_name_char();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? "-" : ".";
            1: return $urandom_range("0", "9");
            2: return 'hB7;
            3: return $urandom_range('h300, 'h36F);
            4: return $urandom_range('h203F, 'h2040);
            default: return pick_name_start();
        endcase
    endfunction

    function automatic int unsigned pick_ref_value();
        int unsigned edges[16] = '{0, 'h9, 'hA, 'hD, 'h1F, 'h20, 'hD7FF, 'hD800,
                                  'hDFFF, 'hE000, 'hFFFD, 'hFFFE, 'hFFFF, 'h10000,
                                  'h10FFFF, 'h110000};
        case ($urandom_range(0, 3))
            0: return edges[$urandom_range(0, 15)];
            1: return $urandom_range(0, 255);
            default: return $urandom_range(0, CP_MAX);
        endcase
    endfunction

    task automatic add_terminator();
        if ($urandom_range(0, 9) == 0) begin
            add_char(pick_any());
        end else begin
            add_char(CH_SEMI);
        end
    endtask

    task automatic add_entity_ref();
        int unsigned n;
        n = $urandom_range(0, 6);
        add_char(CH_AMP);
        add_char(pick_name_start());
        repeat (n) begin
            add_char(pick_name_char());
        end
        add_terminator();
    endtask

    task automatic add_char_ref(bit hexform);
        string       digits;
        int unsigned v;
        v = pick_ref_value();
        digits = hexform ? $sformatf("%0h", v) : $sformatf("%0d", v);
        if ($urandom_range(0, 3) == 0) begin
            digits = {"00", digits};
        end
        if ($urandom_range(0, 19) == 0) begin
            digits = "";
        end
        add_char(CH_AMP);
        add_char(CH_HASH);
        if (hexform) begin
            add_char(CH_X);
        end
        foreach (digits[i]) begin
            if (digits[i] >= "a" && digits[i] <= "f" && $urandom_range(0, 1)) begin
                add_char(digits[i] - 8'd32);
            end else begin
                add_char(digits[i]);
            end
        end
        add_terminator();
    endtask

    task automatic add_broken_ref();
        add_char(CH_AMP);
        if ($urandom_range(0, 1)) begin
            add_char(CH_HASH);
            if ($urandom_range(0, 1)) begin
                add_char(CH_X);
            end
        end
        add_char(pick_any());
    endtask

    // driver: new item only once the previous one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (results_seen >= 300 && results_seen < 420) ||
                           $urandom_range(0, 99) >= 33;
            if (!i_in_valid || in_taken) begin
                if (char_items.size() != 0 &&
                    !(char_items[0].hold && due_results.size() != 0) &&
                    ((items_taken >= 300 && items_taken < 420) ||
                     $urandom_range(0, 99) >= 33)) begin
                    i_code_point <= char_items[0].cp;
                    char_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check results in order, predict each taken item
    always @(posedge i_clk) begin : monitor
        t_parse_result want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $error("result with nothing expected: status %0d value %0h",
                           o_status, o_value);
                    failures++;
                end else begin
                    want = due_results.pop_front();
                    if (want.status <= ST_ERROR) begin
                        status_tally[want.status]++;
                    end
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, o_status);
                        failures++;
                    end
                    if (o_value !== want.value) begin
                        $error("value mismatch: expected %0h, actual %0h",
                               want.value, o_value);
                        failures++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                due_results = {due_results, parse_step(i_code_point)};
                items_taken++;
            end
        end
    end

    initial begin
        add_text("&a;");
        add_text("&#9;");
        add_text("&#x10FFFF;");
        add_text("&#X");
        add_text("&#x;");
        add_text("a");
        add_char(CP_MAX);
        add_char(0);
        pause_next = 1'b1;
        while (queued < ITEM_GOAL) begin
            if (queued / 200 != (queued + 8) / 200) begin
                pause_next = 1'b1;
            end
            case ($urandom_range(0, 9)) inside
                [0:2]:   add_entity_ref();
                [3:4]:   add_char_ref(1'b0);
                [5:7]:   add_char_ref(1'b1);
                8:       add_broken_ref();
                default: add_char(pick_any());
            endcase
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (char_items.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
        if (due_results.size() != 0 || o_out_valid) begin
            $error("%0d results still expected at end", due_results.size());
            failures++;
        end

        $display("%0d characters parsed into %0d results", items_taken, results_seen);
        $display("%0d name chars, %0d entity refs, %0d char refs, %0d errors",
                 status_tally[ST_NAMECHAR], status_tally[ST_ENTDONE],
                 status_tally[ST_CHARDONE], status_tally[ST_ERROR]);
        if (failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/xrp_pkg.sv
design/xrp_char_class.sv
design/xml_reference_parser_core.sv
tb/sv/testbench.sv
